@@ rtl/core/obb_pkg.sv @@
// Shared widths, stage payload types and axis codes for the 2D box overlap test.
// No dependencies; all files in rtl/core except obb_result_if refer to it by scoped names.
`timescale 1ns / 1ps

package obb_pkg;

    // Field widths
    localparam int ROT_W   = 16;   // Q1.14 cosine / sine
    localparam int POS_W   = 32;   // Q16.16 centre coordinate
    localparam int HALF_W  = 31;   // Q15.16 half extent, unsigned
    localparam int SLACK_W = 8;    // rotation slack register

    // Fixed-point alignment
    localparam int ROT_FRAC_BITS = 14;  // slack units, A-axis distance shift, B-axis radius shift
    localparam int A_HALF_SHIFT  = 28;  // own half extent on an A axis
    localparam int B_HALF_SHIFT  = 42;  // own half extent on a B axis

    // Internal widths
    localparam int DIFF_W  = POS_W + 1;            // centre difference
    localparam int RPROD_W = 2 * ROT_W;            // rotation product
    localparam int R_W     = RPROD_W + 1;          // relative rotation entry
    localparam int F_W     = RPROD_W;              // |R| + slack, unsigned
    localparam int TPROD_W = ROT_W + DIFF_W;       // rotation times difference
    localparam int T_W     = TPROD_W + 1;          // offset in box A frame
    localparam int TABS_W  = TPROD_W;              // |T|
    localparam int TLO_W   = 25;                   // low slice of T, unsigned
    localparam int THI_W   = T_W - TLO_W;          // high slice of T, signed
    localparam int PLO_W   = R_W + TLO_W + 1;      // R times low slice
    localparam int PHI_W   = R_W + THI_W;          // R times high slice
    localparam int Q_W     = PHI_W + TLO_W;        // full R times T
    localparam int V_W     = Q_W + 1;              // B-axis projected distance
    localparam int FH_W    = F_W + HALF_W;         // |R| + slack times half extent
    localparam int RHSA_W  = FH_W + 2;             // A-axis radius sum
    localparam int SB_W    = FH_W + 1;             // B-axis radius partial sum
    localparam int RHSB_W  = SB_W + ROT_FRAC_BITS + 2;  // B-axis radius sum

    localparam int STAGES = 7;
    localparam logic [SLACK_W-1:0] SLACK_RESET = SLACK_W'(1);

    // Result codes of the separating axis field
    typedef enum logic [2:0] {
        AXIS_A0   = 3'd0,
        AXIS_B0   = 3'd1,
        AXIS_A1   = 3'd2,
        AXIS_B1   = 3'd3,
        AXIS_NONE = 3'd4
    } sep_axis_t;

    typedef struct packed {
        logic [HALF_W-1:0] a0;
        logic [HALF_W-1:0] a1;
        logic [HALF_W-1:0] b0;
        logic [HALF_W-1:0] b1;
    } halves_t;

    typedef struct packed {
        logic signed [ROT_W-1:0] a_cos;
        logic signed [ROT_W-1:0] a_sin;
        logic signed [POS_W-1:0] a_x;
        logic signed [POS_W-1:0] a_y;
        logic signed [ROT_W-1:0] b_cos;
        logic signed [ROT_W-1:0] b_sin;
        logic signed [POS_W-1:0] b_x;
        logic signed [POS_W-1:0] b_y;
        halves_t                 halves;
    } box_pair_t;

    typedef struct packed {
        logic signed [T_W-1:0] t0;
        logic signed [T_W-1:0] t1;
        logic signed [R_W-1:0] r00;
        logic signed [R_W-1:0] r01;
        logic [F_W-1:0]        f00;
        logic [F_W-1:0]        f01;
        halves_t               halves;
    } front_data_t;

    typedef struct packed {
        logic [RHSA_W-1:0]     rhs_a0;
        logic [RHSA_W-1:0]     rhs_a1;
        logic [SB_W-1:0]       sum_b0;
        logic [SB_W-1:0]       sum_b1;
        logic [TABS_W-1:0]     t0_abs;
        logic [TABS_W-1:0]     t1_abs;
        logic signed [Q_W-1:0] q00t0;
        logic signed [Q_W-1:0] q01t1;
        logic signed [Q_W-1:0] q01t0;
        logic signed [Q_W-1:0] q00t1;
        logic [HALF_W-1:0]     b0;
        logic [HALF_W-1:0]     b1;
    } mult_data_t;

endpackage

@@ rtl/core/obb_box_if.sv @@
// Valid/ready channel carrying one pair of oriented boxes per beat.
// Depends on obb_pkg for field widths.
`timescale 1ns / 1ps

interface obb_box_if;
    logic                             valid;
    logic                             ready;
    logic signed [obb_pkg::ROT_W-1:0] box_a_cos;
    logic signed [obb_pkg::ROT_W-1:0] box_a_sin;
    logic signed [obb_pkg::POS_W-1:0] box_a_x;
    logic signed [obb_pkg::POS_W-1:0] box_a_y;
    logic [obb_pkg::HALF_W-1:0]       box_a_half_x;
    logic [obb_pkg::HALF_W-1:0]       box_a_half_y;
    logic signed [obb_pkg::ROT_W-1:0] box_b_cos;
    logic signed [obb_pkg::ROT_W-1:0] box_b_sin;
    logic signed [obb_pkg::POS_W-1:0] box_b_x;
    logic signed [obb_pkg::POS_W-1:0] box_b_y;
    logic [obb_pkg::HALF_W-1:0]       box_b_half_x;
    logic [obb_pkg::HALF_W-1:0]       box_b_half_y;

    modport source (
        output valid, box_a_cos, box_a_sin, box_a_x, box_a_y, box_a_half_x, box_a_half_y,
               box_b_cos, box_b_sin, box_b_x, box_b_y, box_b_half_x, box_b_half_y,
        input  ready
    );

    modport sink (
        input  valid, box_a_cos, box_a_sin, box_a_x, box_a_y, box_a_half_x, box_a_half_y,
               box_b_cos, box_b_sin, box_b_x, box_b_y, box_b_half_x, box_b_half_y,
        output ready
    );
endinterface

@@ rtl/core/obb_result_if.sv @@
// Valid/ready channel carrying one overlap verdict per beat.
// No dependencies.
`timescale 1ns / 1ps

interface obb_result_if;
    logic       valid;
    logic       ready;
    logic       boxes_overlap;
    logic [2:0] separating_axis;

    modport source (
        output valid, boxes_overlap, separating_axis,
        input  ready
    );

    modport sink (
        input  valid, boxes_overlap, separating_axis,
        output ready
    );
endinterface

@@ rtl/core/obb_front.sv @@
// Front stages 1-3: centre difference, relative rotation, offset in box A frame, |R| + slack.
// Depends on obb_pkg for widths and stage payload types.
`timescale 1ns / 1ps

module obb_front (
    input  logic                              clk,
    input  logic [2:0]                        stage_en,
    input  logic [obb_pkg::SLACK_W-1:0]       rotation_slack,
    input  obb_pkg::box_pair_t                box,
    output obb_pkg::front_data_t              front_out
);

    // Stage 1 registers
    logic signed [obb_pkg::ROT_W-1:0]   ca_reg, sa_reg;
    logic signed [obb_pkg::DIFF_W-1:0]  tx_reg, ty_reg;
    logic signed [obb_pkg::RPROD_W-1:0] p_cc_reg, p_ss_reg, p_sc_reg, p_cs_reg;
    obb_pkg::halves_t                   halves_s1_reg;

    // Stage 2 registers
    logic signed [obb_pkg::R_W-1:0]     r00_reg, r01_reg;
    logic signed [obb_pkg::TPROD_W-1:0] p_ctx_reg, p_sty_reg, p_cty_reg, p_stx_reg;
    obb_pkg::halves_t                   halves_s2_reg;

    // Stage 3 register
    obb_pkg::front_data_t               front_reg;

    // Stage 2 and 3 logic
    logic signed [obb_pkg::R_W-1:0]     r00_next, r01_next;
    logic [obb_pkg::R_W-1:0]            r00_abs, r01_abs;
    logic [obb_pkg::F_W-1:0]            slack_ext;
    obb_pkg::front_data_t               front_next;

    // Stage 1: centre difference and the four rotation products
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            ca_reg        <= box.a_cos;
            sa_reg        <= box.a_sin;
            tx_reg        <= obb_pkg::DIFF_W'(box.b_x) - obb_pkg::DIFF_W'(box.a_x);
            ty_reg        <= obb_pkg::DIFF_W'(box.b_y) - obb_pkg::DIFF_W'(box.a_y);
            p_cc_reg      <= obb_pkg::RPROD_W'(box.a_cos) * obb_pkg::RPROD_W'(box.b_cos);
            p_ss_reg      <= obb_pkg::RPROD_W'(box.a_sin) * obb_pkg::RPROD_W'(box.b_sin);
            p_sc_reg      <= obb_pkg::RPROD_W'(box.a_sin) * obb_pkg::RPROD_W'(box.b_cos);
            p_cs_reg      <= obb_pkg::RPROD_W'(box.a_cos) * obb_pkg::RPROD_W'(box.b_sin);
            halves_s1_reg <= box.halves;
        end
    end

    // Stage 2: sum rotation entries; R10 = -R01 and R11 = R00 need no logic of their own
    always_comb
    begin
        r00_next = obb_pkg::R_W'(p_cc_reg) + obb_pkg::R_W'(p_ss_reg);
        r01_next = obb_pkg::R_W'(p_sc_reg) - obb_pkg::R_W'(p_cs_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            r00_reg       <= r00_next;
            r01_reg       <= r01_next;
            p_ctx_reg     <= obb_pkg::TPROD_W'(ca_reg) * obb_pkg::TPROD_W'(tx_reg);
            p_sty_reg     <= obb_pkg::TPROD_W'(sa_reg) * obb_pkg::TPROD_W'(ty_reg);
            p_cty_reg     <= obb_pkg::TPROD_W'(ca_reg) * obb_pkg::TPROD_W'(ty_reg);
            p_stx_reg     <= obb_pkg::TPROD_W'(sa_reg) * obb_pkg::TPROD_W'(tx_reg);
            halves_s2_reg <= halves_s1_reg;
        end
    end

    // Stage 3: offset in A frame, |R| plus slack
    always_comb
    begin
        r00_abs   = r00_reg[obb_pkg::R_W-1] ? obb_pkg::R_W'(-r00_reg) : obb_pkg::R_W'(r00_reg);
        r01_abs   = r01_reg[obb_pkg::R_W-1] ? obb_pkg::R_W'(-r01_reg) : obb_pkg::R_W'(r01_reg);
        slack_ext = obb_pkg::F_W'(rotation_slack) << obb_pkg::ROT_FRAC_BITS;

        front_next.t0     = obb_pkg::T_W'(p_ctx_reg) + obb_pkg::T_W'(p_sty_reg);
        front_next.t1     = obb_pkg::T_W'(p_cty_reg) - obb_pkg::T_W'(p_stx_reg);
        front_next.r00    = r00_reg;
        front_next.r01    = r01_reg;
        front_next.f00    = obb_pkg::F_W'(r00_abs) + slack_ext;
        front_next.f01    = obb_pkg::F_W'(r01_abs) + slack_ext;
        front_next.halves = halves_s2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            front_reg <= front_next;
        end
    end

    assign front_out = front_reg;

endmodule

@@ rtl/core/obb_mult.sv @@
// Multiply stages 4-5: radius products, sliced R*T products and their recombination.
// Depends on obb_pkg for widths and stage payload types.
`timescale 1ns / 1ps

module obb_mult (
    input  logic                  clk,
    input  logic [1:0]            stage_en,
    input  obb_pkg::front_data_t  front_in,
    output obb_pkg::mult_data_t   mult_out
);

    // Slices of the offset: unsigned low part, signed high part
    logic signed [obb_pkg::TLO_W:0]   t0_lo, t1_lo;
    logic signed [obb_pkg::THI_W-1:0] t0_hi, t1_hi;

    // Stage 4 registers
    logic signed [obb_pkg::PLO_W-1:0] l00t0_reg, l01t1_reg, l01t0_reg, l00t1_reg;
    logic signed [obb_pkg::PHI_W-1:0] h00t0_reg, h01t1_reg, h01t0_reg, h00t1_reg;
    logic [obb_pkg::FH_W-1:0]         f00b0_reg, f01b1_reg, f01b0_reg, f00b1_reg;
    logic [obb_pkg::FH_W-1:0]         f00a0_reg, f01a1_reg, f01a0_reg, f00a1_reg;
    logic [obb_pkg::TABS_W-1:0]       t0_abs_reg, t1_abs_reg;
    obb_pkg::halves_t                 halves_s4_reg;

    // Stage 5 register
    obb_pkg::mult_data_t              mult_reg;
    obb_pkg::mult_data_t              mult_next;

    // Cut T into slices so every product stays near 32 x 32
    always_comb
    begin
        t0_lo = $signed({1'b0, front_in.t0[obb_pkg::TLO_W-1:0]});
        t1_lo = $signed({1'b0, front_in.t1[obb_pkg::TLO_W-1:0]});
        t0_hi = $signed(front_in.t0[obb_pkg::T_W-1:obb_pkg::TLO_W]);
        t1_hi = $signed(front_in.t1[obb_pkg::T_W-1:obb_pkg::TLO_W]);
    end

    // Stage 4: all products
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            l00t0_reg <= obb_pkg::PLO_W'(front_in.r00) * obb_pkg::PLO_W'(t0_lo);
            l01t1_reg <= obb_pkg::PLO_W'(front_in.r01) * obb_pkg::PLO_W'(t1_lo);
            l01t0_reg <= obb_pkg::PLO_W'(front_in.r01) * obb_pkg::PLO_W'(t0_lo);
            l00t1_reg <= obb_pkg::PLO_W'(front_in.r00) * obb_pkg::PLO_W'(t1_lo);
            h00t0_reg <= obb_pkg::PHI_W'(front_in.r00) * obb_pkg::PHI_W'(t0_hi);
            h01t1_reg <= obb_pkg::PHI_W'(front_in.r01) * obb_pkg::PHI_W'(t1_hi);
            h01t0_reg <= obb_pkg::PHI_W'(front_in.r01) * obb_pkg::PHI_W'(t0_hi);
            h00t1_reg <= obb_pkg::PHI_W'(front_in.r00) * obb_pkg::PHI_W'(t1_hi);

            f00b0_reg <= obb_pkg::FH_W'(front_in.f00) * obb_pkg::FH_W'(front_in.halves.b0);
            f01b1_reg <= obb_pkg::FH_W'(front_in.f01) * obb_pkg::FH_W'(front_in.halves.b1);
            f01b0_reg <= obb_pkg::FH_W'(front_in.f01) * obb_pkg::FH_W'(front_in.halves.b0);
            f00b1_reg <= obb_pkg::FH_W'(front_in.f00) * obb_pkg::FH_W'(front_in.halves.b1);
            f00a0_reg <= obb_pkg::FH_W'(front_in.f00) * obb_pkg::FH_W'(front_in.halves.a0);
            f01a1_reg <= obb_pkg::FH_W'(front_in.f01) * obb_pkg::FH_W'(front_in.halves.a1);
            f01a0_reg <= obb_pkg::FH_W'(front_in.f01) * obb_pkg::FH_W'(front_in.halves.a0);
            f00a1_reg <= obb_pkg::FH_W'(front_in.f00) * obb_pkg::FH_W'(front_in.halves.a1);

            t0_abs_reg <= front_in.t0[obb_pkg::T_W-1] ?
                          obb_pkg::TABS_W'(-front_in.t0) : obb_pkg::TABS_W'(front_in.t0);
            t1_abs_reg <= front_in.t1[obb_pkg::T_W-1] ?
                          obb_pkg::TABS_W'(-front_in.t1) : obb_pkg::TABS_W'(front_in.t1);
            halves_s4_reg <= front_in.halves;
        end
    end

    // Stage 5: A-axis radii, B-axis radius partials, recombine R*T slices
    always_comb
    begin
        mult_next.rhs_a0 = (obb_pkg::RHSA_W'(halves_s4_reg.a0) << obb_pkg::A_HALF_SHIFT)
                         + obb_pkg::RHSA_W'(f00b0_reg) + obb_pkg::RHSA_W'(f01b1_reg);
        mult_next.rhs_a1 = (obb_pkg::RHSA_W'(halves_s4_reg.a1) << obb_pkg::A_HALF_SHIFT)
                         + obb_pkg::RHSA_W'(f01b0_reg) + obb_pkg::RHSA_W'(f00b1_reg);
        mult_next.sum_b0 = obb_pkg::SB_W'(f00a0_reg) + obb_pkg::SB_W'(f01a1_reg);
        mult_next.sum_b1 = obb_pkg::SB_W'(f01a0_reg) + obb_pkg::SB_W'(f00a1_reg);
        mult_next.t0_abs = t0_abs_reg;
        mult_next.t1_abs = t1_abs_reg;
        mult_next.q00t0  = (obb_pkg::Q_W'(h00t0_reg) << obb_pkg::TLO_W) + obb_pkg::Q_W'(l00t0_reg);
        mult_next.q01t1  = (obb_pkg::Q_W'(h01t1_reg) << obb_pkg::TLO_W) + obb_pkg::Q_W'(l01t1_reg);
        mult_next.q01t0  = (obb_pkg::Q_W'(h01t0_reg) << obb_pkg::TLO_W) + obb_pkg::Q_W'(l01t0_reg);
        mult_next.q00t1  = (obb_pkg::Q_W'(h00t1_reg) << obb_pkg::TLO_W) + obb_pkg::Q_W'(l00t1_reg);
        mult_next.b0     = halves_s4_reg.b0;
        mult_next.b1     = halves_s4_reg.b1;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            mult_reg <= mult_next;
        end
    end

    assign mult_out = mult_reg;

endmodule

@@ rtl/core/obb_axis.sv @@
// Axis stages 6-7: strict compares on the four face axes and first-hit selection.
// Depends on obb_pkg for widths and axis codes.
`timescale 1ns / 1ps

module obb_axis (
    input  logic                 clk,
    input  logic [1:0]           stage_en,
    input  obb_pkg::mult_data_t  mult_in,
    output logic                 boxes_overlap,
    output logic [2:0]           separating_axis
);

    // Stage 6 logic and registers
    logic [obb_pkg::RHSB_W-1:0]     rhs_b0_u, rhs_b1_u;
    logic signed [obb_pkg::V_W-1:0] rhs_b0_pos, rhs_b1_pos;
    logic                           sep_a0_reg, sep_a1_reg;
    logic signed [obb_pkg::V_W-1:0] v_b0_reg, v_b1_reg;
    logic signed [obb_pkg::V_W-1:0] pos_b0_reg, pos_b1_reg, neg_b0_reg, neg_b1_reg;

    // Stage 7 logic and registers
    logic                           sep_b0, sep_b1;
    obb_pkg::sep_axis_t             axis_next;
    obb_pkg::sep_axis_t             axis_reg;
    logic                           overlap_reg;

    always_comb
    begin
        rhs_b0_u = (obb_pkg::RHSB_W'(mult_in.b0) << obb_pkg::B_HALF_SHIFT)
                 + (obb_pkg::RHSB_W'(mult_in.sum_b0) << obb_pkg::ROT_FRAC_BITS);
        rhs_b1_u = (obb_pkg::RHSB_W'(mult_in.b1) << obb_pkg::B_HALF_SHIFT)
                 + (obb_pkg::RHSB_W'(mult_in.sum_b1) << obb_pkg::ROT_FRAC_BITS);
        rhs_b0_pos = $signed(obb_pkg::V_W'(rhs_b0_u));
        rhs_b1_pos = $signed(obb_pkg::V_W'(rhs_b1_u));
    end

    // Stage 6: decide A axes, form B-axis distance and both signs of its radius
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            sep_a0_reg <= (obb_pkg::RHSA_W'(mult_in.t0_abs) << obb_pkg::ROT_FRAC_BITS)
                          > mult_in.rhs_a0;
            sep_a1_reg <= (obb_pkg::RHSA_W'(mult_in.t1_abs) << obb_pkg::ROT_FRAC_BITS)
                          > mult_in.rhs_a1;
            v_b0_reg   <= obb_pkg::V_W'(mult_in.q00t0) - obb_pkg::V_W'(mult_in.q01t1);
            v_b1_reg   <= obb_pkg::V_W'(mult_in.q01t0) + obb_pkg::V_W'(mult_in.q00t1);
            pos_b0_reg <= rhs_b0_pos;
            pos_b1_reg <= rhs_b1_pos;
            neg_b0_reg <= -rhs_b0_pos;
            neg_b1_reg <= -rhs_b1_pos;
        end
    end

    // Stage 7: |v| > r taken as v > r or v < -r; first separating axis wins
    always_comb
    begin
        sep_b0 = (v_b0_reg > pos_b0_reg) || (v_b0_reg < neg_b0_reg);
        sep_b1 = (v_b1_reg > pos_b1_reg) || (v_b1_reg < neg_b1_reg);
        priority if (sep_a0_reg)
            axis_next = obb_pkg::AXIS_A0;
        else if (sep_b0)
            axis_next = obb_pkg::AXIS_B0;
        else if (sep_a1_reg)
            axis_next = obb_pkg::AXIS_A1;
        else if (sep_b1)
            axis_next = obb_pkg::AXIS_B1;
        else
            axis_next = obb_pkg::AXIS_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            axis_reg    <= axis_next;
            overlap_reg <= (axis_next == obb_pkg::AXIS_NONE);
        end
    end

    assign boxes_overlap   = overlap_reg;
    assign separating_axis = axis_reg;

endmodule

@@ rtl/core/obb_overlap_2d_sat.sv @@
// Top level of the 2D oriented box overlap test: handshake, stage control, slack register.
// Depends on obb_pkg, obb_box_if, obb_result_if, obb_front, obb_mult and obb_axis.
`timescale 1ns / 1ps

// Usage
//   box_in carries one pair of oriented boxes per beat; result_out returns one
//   verdict per beat, in input order: boxes_overlap and the first separating
//   axis (A axis 0, B axis 0, A axis 1, B axis 1, or none).
//   cfg_we / cfg_wdata write rotation_slack; write it only while the pipe is empty.
// Pipeline and throughput
//   Seven register stages. One beat per cycle is sustained while result_out.ready
//   stays high; the depth is set by the sliced R*T multiplies and the wide
//   radius sums and compares, one register level each.
// Reset
//   rst_n clears every stage valid bit and sets rotation_slack to 1.
// Stalls
//   When result_out.ready is low, the last stage holds its beat; earlier stages
//   keep filling empty slots, and box_in.ready drops only once every stage holds
//   a beat. Nothing is dropped or repeated.

module obb_overlap_2d_sat (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [obb_pkg::SLACK_W-1:0] cfg_wdata,
    obb_box_if.sink                     box_in,
    obb_result_if.source                result_out
);

    localparam int LAST = obb_pkg::STAGES - 1;

    logic [obb_pkg::SLACK_W-1:0] rotation_slack_reg;
    logic [obb_pkg::STAGES-1:0]  valid_reg;
    logic [obb_pkg::STAGES-1:0]  valid_next;
    logic [obb_pkg::STAGES-1:0]  stage_en;
    obb_pkg::box_pair_t          box;
    obb_pkg::front_data_t        front_data;
    obb_pkg::mult_data_t         mult_data;

    // Hold the slack register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rotation_slack_reg <= obb_pkg::SLACK_RESET;
        else if (cfg_we)
            rotation_slack_reg <= cfg_wdata;
    end

    // Advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        stage_en[LAST] = !valid_reg[LAST] || result_out.ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i + 1];
        end
        valid_next[0] = stage_en[0] ? box_in.valid : valid_reg[0];
        for (int i = 1; i < obb_pkg::STAGES; i++)
        begin
            valid_next[i] = stage_en[i] ? valid_reg[i - 1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Gather the input beat
    always_comb
    begin
        box.a_cos     = box_in.box_a_cos;
        box.a_sin     = box_in.box_a_sin;
        box.a_x       = box_in.box_a_x;
        box.a_y       = box_in.box_a_y;
        box.b_cos     = box_in.box_b_cos;
        box.b_sin     = box_in.box_b_sin;
        box.b_x       = box_in.box_b_x;
        box.b_y       = box_in.box_b_y;
        box.halves.a0 = box_in.box_a_half_x;
        box.halves.a1 = box_in.box_a_half_y;
        box.halves.b0 = box_in.box_b_half_x;
        box.halves.b1 = box_in.box_b_half_y;
    end

    assign box_in.ready     = stage_en[0];
    assign result_out.valid = valid_reg[LAST];

    obb_front u_front (
        .clk            (clk),
        .stage_en       (stage_en[2:0]),
        .rotation_slack (rotation_slack_reg),
        .box            (box),
        .front_out      (front_data)
    );

    obb_mult u_mult (
        .clk      (clk),
        .stage_en (stage_en[4:3]),
        .front_in (front_data),
        .mult_out (mult_data)
    );

    obb_axis u_axis (
        .clk             (clk),
        .stage_en        (stage_en[6:5]),
        .mult_in         (mult_data),
        .boxes_overlap   (result_out.boxes_overlap),
        .separating_axis (result_out.separating_axis)
    );

`ifndef NO_ASSERTIONS
    // Overlap flag and axis code agree on every delivered beat
    a_overlap_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |->
            (result_out.boxes_overlap == (result_out.separating_axis == obb_pkg::AXIS_NONE)))
        else $error("overlap flag and axis code disagree");

    // Axis code stays within the defined codes
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (result_out.separating_axis <= obb_pkg::AXIS_NONE))
        else $error("undefined separating axis code");

    // Input backpressure only when every stage is full and the output is stalled
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !box_in.ready |-> ((&valid_reg) && !result_out.ready))
        else $error("input stalled while the pipe has room");

    // An accepted beat lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (box_in.valid && box_in.ready) |=> valid_reg[0])
        else $error("accepted beat lost at pipe entry");
`endif

endmodule

@@ sim/obb_overlap_2d_sat_tb.sv @@
// Self-checking testbench for the 2D oriented box overlap test (separating axis method).
// Depends on obb_pkg, obb_box_if, obb_result_if and the obb_overlap_2d_sat RTL.
`timescale 1ns / 1ps

module obb_overlap_2d_sat_tb;

    localparam int PHASES         = 6;
    localparam int RAND_PER_PHASE = 325;
    localparam int CALM_PHASE     = 2;     // no idling on either side
    localparam int HOLD_PHASE     = 3;     // sender pauses until the pipe is empty
    localparam int DRAIN_CYCLES   = 12;    // seven stages plus margin
    localparam int CYCLE_LIMIT    = 800000;
    localparam int UNIT           = 16384; // 1.0 in Q1.14

    typedef struct packed {
        logic               overlap;
        obb_pkg::sep_axis_t axis;
    } verdict_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [obb_pkg::SLACK_W-1:0] cfg_wdata;

    obb_box_if    box_bus ();
    obb_result_if result_bus ();

    obb_overlap_2d_sat dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .box_in     (box_bus),
        .result_out (result_bus)
    );

    obb_pkg::box_pair_t          pair_q [$];     // box pairs waiting to be sent
    verdict_t                    verdict_q [$];  // verdicts owed by the block, oldest first
    obb_pkg::box_pair_t          beat_pair;      // pair currently on the input bus
    logic [obb_pkg::SLACK_W-1:0] slack_model = obb_pkg::SLACK_RESET;
    logic                        box_fire;
    bit                          calm = 1'b0;
    bit                          hold_sender = 1'b0;
    int                          send_gap = 0;
    int                          stall_left = 0;
    int                          sent_count = 0;
    int                          checked_count = 0;
    int                          fail_count = 0;
    int                          cycle_count = 0;
    int                          axis_hits [5] = '{0, 0, 0, 0, 0};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Absolute value at full width
    function automatic logic signed [127:0] abs_wide(input logic signed [127:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // Work out the verdict for one box pair: exact products, strict compares
    function automatic verdict_t judge_pair(input obb_pkg::box_pair_t p,
                                            input logic [obb_pkg::SLACK_W-1:0] slk8);
        logic signed [127:0] ca, sa, cb, sb, tx, ty, t0, t1;
        logic signed [127:0] r00, r01, r10, r11, f00, f01, f10, f11;
        logic signed [127:0] a0, a1, b0, b1, slk, lhs, rhs;
        verdict_t v;
        ca  = $signed(p.a_cos);
        sa  = $signed(p.a_sin);
        cb  = $signed(p.b_cos);
        sb  = $signed(p.b_sin);
        tx  = $signed(p.b_x);
        tx  = tx - $signed(p.a_x);
        ty  = $signed(p.b_y);
        ty  = ty - $signed(p.a_y);
        a0  = {97'b0, p.halves.a0};
        a1  = {97'b0, p.halves.a1};
        b0  = {97'b0, p.halves.b0};
        b1  = {97'b0, p.halves.b1};
        slk = {106'b0, slk8, 14'b0};
        // offset in the frame of A (30 fraction bits), relative rotation (28)
        t0  = ca * tx + sa * ty;
        t1  = ca * ty - sa * tx;
        r00 = ca * cb + sa * sb;
        r01 = sa * cb - ca * sb;
        r10 = ca * sb - sa * cb;
        r11 = sa * sb + ca * cb;
        f00 = abs_wide(r00) + slk;
        f01 = abs_wide(r01) + slk;
        f10 = abs_wide(r10) + slk;
        f11 = abs_wide(r11) + slk;
        v.axis = obb_pkg::AXIS_NONE;
        // axis 0 of A
        lhs = abs_wide(t0) <<< 14;
        rhs = (a0 <<< 28) + f00 * b0 + f01 * b1;
        if (lhs > rhs)
            v.axis = obb_pkg::AXIS_A0;
        // axis 0 of B
        if (v.axis == obb_pkg::AXIS_NONE)
        begin
            lhs = abs_wide(r00 * t0 + r10 * t1);
            rhs = (b0 <<< 42) + ((f00 * a0 + f10 * a1) <<< 14);
            if (lhs > rhs)
                v.axis = obb_pkg::AXIS_B0;
        end
        // axis 1 of A
        if (v.axis == obb_pkg::AXIS_NONE)
        begin
            lhs = abs_wide(t1) <<< 14;
            rhs = (a1 <<< 28) + f10 * b0 + f11 * b1;
            if (lhs > rhs)
                v.axis = obb_pkg::AXIS_A1;
        end
        // axis 1 of B
        if (v.axis == obb_pkg::AXIS_NONE)
        begin
            lhs = abs_wide(r01 * t0 + r11 * t1);
            rhs = (b1 <<< 42) + ((f01 * a0 + f11 * a1) <<< 14);
            if (lhs > rhs)
                v.axis = obb_pkg::AXIS_B1;
        end
        v.overlap = (v.axis == obb_pkg::AXIS_NONE);
        return v;
    endfunction

    function automatic obb_pkg::box_pair_t make_pair(input int ac, input int asn, input int ax,
                                                     input int ay, input int ah0, input int ah1,
                                                     input int bc, input int bsn, input int bx,
                                                     input int by, input int bh0, input int bh1);
        obb_pkg::box_pair_t p;
        p.a_cos     = ac[obb_pkg::ROT_W-1:0];
        p.a_sin     = asn[obb_pkg::ROT_W-1:0];
        p.a_x       = ax;
        p.a_y       = ay;
        p.b_cos     = bc[obb_pkg::ROT_W-1:0];
        p.b_sin     = bsn[obb_pkg::ROT_W-1:0];
        p.b_x       = bx;
        p.b_y       = by;
        p.halves.a0 = ah0[obb_pkg::HALF_W-1:0];
        p.halves.a1 = ah1[obb_pkg::HALF_W-1:0];
        p.halves.b0 = bh0[obb_pkg::HALF_W-1:0];
        p.halves.b1 = bh1[obb_pkg::HALF_W-1:0];
        return p;
    endfunction

    function automatic int to_q14(input real v);
        return $rtoi(v * 16384.0 + ((v < 0.0) ? -0.5 : 0.5));
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        return ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(40, 8);
    endfunction

    // Random pair: nearby unit-rotation boxes, quarter-turn boxes on a grid, or raw noise
    function automatic obb_pkg::box_pair_t rand_pair();
        int     qc [4] = '{UNIT, 0, -UNIT, 0};
        int     qs [4] = '{0, UNIT, 0, -UNIT};
        int     pick, scale, mask, ax, ay, qa, qb;
        longint span, offx, offy;
        real    ta, tb;
        pick = $urandom_range(99);
        ax   = int'($urandom) >>> 2;
        ay   = int'($urandom) >>> 2;
        if (pick < 25)
            return make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (pick < 45)
        begin
            // quarter turns and whole units, so ties on an axis come up often
            qa = $urandom_range(3);
            qb = $urandom_range(3);
            return make_pair(qc[qa], qs[qa], ax, ay,
                             $urandom_range(6) << 16, $urandom_range(6) << 16,
                             qc[qb], qs[qb],
                             ax + ((int'($urandom_range(24)) - 12) <<< 16),
                             ay + ((int'($urandom_range(24)) - 12) <<< 16),
                             $urandom_range(6) << 16, $urandom_range(6) << 16);
        end
        scale = ($urandom_range(9) == 0) ? $urandom_range(28, 21) : $urandom_range(20, 6);
        mask  = (1 << scale) - 1;
        span  = longint'(1) << (scale + 1);
        offx  = longint'($urandom) % (2 * span + 1) - span;
        offy  = longint'($urandom) % (2 * span + 1) - span;
        ta    = $urandom_range(35999) * 3.14159265358979 / 18000.0;
        tb    = $urandom_range(35999) * 3.14159265358979 / 18000.0;
        return make_pair(to_q14($cos(ta)), to_q14($sin(ta)), ax, ay,
                         $urandom & mask, $urandom & mask,
                         to_q14($cos(tb)), to_q14($sin(tb)), ax + int'(offx), ay + int'(offy),
                         $urandom & mask, $urandom & mask);
    endfunction

    task automatic put_beat(input obb_pkg::box_pair_t p);
        box_bus.box_a_cos    <= p.a_cos;
        box_bus.box_a_sin    <= p.a_sin;
        box_bus.box_a_x      <= p.a_x;
        box_bus.box_a_y      <= p.a_y;
        box_bus.box_a_half_x <= p.halves.a0;
        box_bus.box_a_half_y <= p.halves.a1;
        box_bus.box_b_cos    <= p.b_cos;
        box_bus.box_b_sin    <= p.b_sin;
        box_bus.box_b_x      <= p.b_x;
        box_bus.box_b_y      <= p.b_y;
        box_bus.box_b_half_x <= p.halves.b0;
        box_bus.box_b_half_y <= p.halves.b1;
    endtask

    // Wait until nothing is queued, in flight or owed, then let the pipe settle
    task automatic drain_pipe();
        while (pair_q.size() != 0 || box_bus.valid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Input driver: present the next pair once the slot is free and the gap has run out
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            box_bus.valid <= 1'b0;
            put_beat('0);
        end
        else if (!box_bus.valid || box_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                box_bus.valid <= 1'b0;
            end
            else if (pair_q.size() != 0 && !hold_sender)
            begin
                beat_pair = pair_q.pop_front();
                put_beat(beat_pair);
                box_bus.valid <= 1'b1;
                sent_count = sent_count + 1;
                send_gap = (calm || $urandom_range(99) < 50) ? 0 : idle_len();
            end
            else
                box_bus.valid <= 1'b0;
        end
    end

    // Output back-pressure: random stalls of random length
    always @(negedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_bus.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(99) < 20)
        begin
            stall_left = idle_len() - 1;
            result_bus.ready <= 1'b0;
        end
        else
            result_bus.ready <= 1'b1;
    end

    // Monitor: track the slack register, queue verdicts on input beats, check output beats
    always @(posedge clk)
    begin : monitor
        verdict_t want;
        if (!rst_n)
        begin
            box_fire    <= 1'b0;
            slack_model <= obb_pkg::SLACK_RESET;
        end
        else
        begin
            if (cfg_we)
                slack_model <= cfg_wdata;
            box_fire <= box_bus.valid && box_bus.ready;
            if (result_bus.valid && result_bus.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("unexpected verdict: overlap %0b axis %0d",
                                 result_bus.boxes_overlap, result_bus.separating_axis);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    axis_hits[int'(want.axis)] = axis_hits[int'(want.axis)] + 1;
                    if (result_bus.boxes_overlap !== want.overlap ||
                        result_bus.separating_axis !== want.axis)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("verdict %0d: overlap exp %0b got %0b, axis exp %0d got %0d",
                                     checked_count, want.overlap, result_bus.boxes_overlap,
                                     want.axis, result_bus.separating_axis);
                    end
                    checked_count = checked_count + 1;
                end
            end
            if (box_bus.valid && box_bus.ready)
                verdict_q.push_back(judge_pair(beat_pair, slack_model));
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles, %0d verdicts owed",
                     cycle_count, verdict_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus: directed pairs, then random pairs over several slack settings
    initial
    begin
        logic [obb_pkg::SLACK_W-1:0] slack_plan [PHASES];
        slack_plan[0] = obb_pkg::SLACK_RESET;
        slack_plan[1] = 8'd0;
        slack_plan[2] = 8'd255;
        slack_plan[3] = 8'($urandom_range(254, 2));
        slack_plan[4] = 8'd128;
        slack_plan[5] = 8'($urandom_range(254, 2));
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        rst_n            = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // write the slack register only with the pipe empty
            if (ph != 0)
            begin
                drain_pipe();
                cfg_we    <= 1'b1;
                cfg_wdata <= slack_plan[ph];
                @(negedge clk);
                cfg_we    <= 1'b0;
                repeat (2) @(negedge clk);
            end
            @(posedge clk);
            calm = (ph == CALM_PHASE);
            if (ph == 0)
            begin
                // Ties below hold with slack 1: halves summing to 1/4 unit make radii whole
                pair_q.push_back(make_pair(UNIT, 0, 0, 0, 0, 0, UNIT, 0, 0, 0, 0, 0));
                pair_q.push_back(make_pair(UNIT, 0, 0, 0, 8192, 8192,
                                           UNIT, 0, 16385, 0, 8192, 8192));
                pair_q.push_back(make_pair(UNIT, 0, 0, 0, 8192, 8192,
                                           UNIT, 0, 16386, 0, 8192, 8192));
                pair_q.push_back(make_pair(UNIT, 0, 16386, 0, 8192, 8192,
                                           UNIT, 0, 0, 0, 8192, 8192));
                pair_q.push_back(make_pair(UNIT, 0, 0, 0, 8192, 8192,
                                           UNIT, 0, 0, 16385, 8192, 8192));
                pair_q.push_back(make_pair(UNIT, 0, 0, 0, 8192, 8192,
                                           UNIT, 0, 0, 16386, 8192, 8192));
                pair_q.push_back(make_pair(UNIT, 0, 0, 0, 8192, 8192,
                                           0, UNIT, 16385, 0, 8192, 8192));
                pair_q.push_back(make_pair(UNIT, 0, 0, 0, 8192, 8192,
                                           0, -UNIT, 0, -16386, 8192, 8192));
                // thin box at 45 degrees, square off its short or long side
                pair_q.push_back(make_pair(UNIT, 0, 0, 0, 65536, 65536,
                                           11585, 11585, 139015, 139015, 6554, 655360));
                pair_q.push_back(make_pair(UNIT, 0, 0, 0, 65536, 65536,
                                           11585, 11585, -139015, 139015, 655360, 6554));
                // extremes of every field
                pair_q.push_back(make_pair(-UNIT, UNIT, 32'h8000_0000, 32'h7FFF_FFFF,
                                           32'h7FFF_FFFF, 32'h7FFF_FFFF, UNIT, -UNIT,
                                           32'h7FFF_FFFF, 32'h8000_0000,
                                           32'h7FFF_FFFF, 32'h7FFF_FFFF));
                pair_q.push_back(make_pair(32767, -32768, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                           -32768, 32767, 0, 0,
                                           32'h7FFF_FFFF, 32'h7FFF_FFFF));
                pair_q.push_back(make_pair(-32768, -32768, 32'h8000_0000, 32'h8000_0000, 0, 0,
                                           -32768, -32768, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
                pair_q.push_back(make_pair(32767, 32767, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
                                           -32768, 32767, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
                // degenerate rotation: all zero
                pair_q.push_back(make_pair(0, 0, 32'h8000_0000, 0, 1, 1,
                                           0, 0, 32'h7FFF_FFFF, 0, 1, 1));
                // zero extents at the same centre, then long thin boxes
                pair_q.push_back(make_pair(UNIT, 0, 12345, -6789, 0, 0,
                                           0, UNIT, 12345, -6789, 0, 0));
                pair_q.push_back(make_pair(0, -UNIT, -5, 7, 32'h4000_0000, 1,
                                           -UNIT, 0, 32'h4000_0000, 7, 1, 32'h4000_0000));
            end
            for (int i = 0; i < RAND_PER_PHASE; i++)
                pair_q.push_back(rand_pair());
            // hold off the sender mid-phase until every owed verdict is back
            if (ph == HOLD_PHASE)
            begin
                while (pair_q.size() > RAND_PER_PHASE / 2)
                    @(posedge clk);
                hold_sender = 1'b1;
                @(negedge clk);
                while (box_bus.valid || verdict_q.size() != 0)
                    @(negedge clk);
                @(posedge clk);
                hold_sender = 1'b0;
            end
        end

        drain_pipe();
        fail_count = fail_count + verdict_q.size();
        $display("sent %0d box pairs over %0d slack settings, checked %0d verdicts",
                 sent_count, PHASES, checked_count);
        $display("verdict mix: overlap %0d, A0 %0d, B0 %0d, A1 %0d, B1 %0d; failures %0d",
                 axis_hits[obb_pkg::AXIS_NONE], axis_hits[obb_pkg::AXIS_A0],
                 axis_hits[obb_pkg::AXIS_B0], axis_hits[obb_pkg::AXIS_A1],
                 axis_hits[obb_pkg::AXIS_B1], fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
